[hdl/pdss_pkg.sv]
// ----------------------------------------------------------------------------
// pdss_pkg
// Types and constants shared by the Phong diffuse/specular shading pipeline.
// ----------------------------------------------------------------------------
package pdss_pkg;

  // Raw vector component width and reduced direction width
  localparam int unsigned COMP_BITS  = 32;
  localparam int unsigned DIR_BITS   = 15;
  localparam int unsigned BL_BITS    = $clog2(COMP_BITS + 1);

  // Specular exponent register
  localparam int unsigned EXP_BITS   = 10;
  localparam logic [EXP_BITS-1:0] EXP_RESET = 10'd300;

  // Intensity, unsigned Q1.16 with 65536 meaning one
  localparam int unsigned INTEN_BITS = 17;
  localparam logic [INTEN_BITS-1:0] FULL_INTEN = 17'd65536;

  // Cosines are signed Q30 in [-2^30, 2^30]
  localparam int unsigned COS_BITS   = 32;
  localparam int unsigned FRAC_Q     = 30;
  localparam int unsigned MAG_BITS   = FRAC_Q + 1;
  localparam int          Q30_ONE    = 1 << FRAC_Q;

  typedef logic signed [COMP_BITS-1:0] comp_t;
  typedef logic signed [DIR_BITS:0]    dir_t;
  typedef comp_t [2:0]                 cvec_t;
  typedef dir_t  [2:0]                 dvec_t;

  // Input request
  typedef struct packed {
    comp_t                  normal_x;
    comp_t                  normal_y;
    comp_t                  normal_z;
    comp_t                  light_x;
    comp_t                  light_y;
    comp_t                  light_z;
    comp_t                  view_x;
    comp_t                  view_y;
    comp_t                  view_z;
    logic [INTEN_BITS-1:0]  light_intensity;
    logic                   in_shadow;
  } pdss_in_t;

  // Result
  typedef struct packed {
    logic [INTEN_BITS-1:0]  diffuse_part;
    logic [INTEN_BITS-1:0]  specular_part;
    logic [INTEN_BITS:0]    total_intensity;
  } pdss_out_t;

  // Sideband carried along the direction and cosine stages
  typedef struct packed {
    logic [INTEN_BITS-1:0]  inten;
    logic                   shadow;
  } pdss_side_t;

  // Sideband carried along the power stages
  typedef struct packed {
    logic [INTEN_BITS-1:0]  inten;
    logic                   shadow;
    logic [INTEN_BITS-1:0]  diff;
    logic                   en;
  } pdss_pside_t;

endpackage

[hdl/phong_diffuse_specular_shade.sv]
// ----------------------------------------------------------------------------
// phong_diffuse_specular_shade
// Phong diffuse and specular terms of one shading point per clock.
//
//   channel   ports                       direction  handshake
//   request   start, busy, req_i          in         start & !busy
//   result    done_o, res_o               out        done_o, one cycle
//   config    cfg_we_i, cfg_wdata_i       in         cfg_we_i
//
// A request may enter on every clock; busy stays low. Each result passes
// through 3 direction stages, 67 cosine stages (norm square root and
// divider, one bit per stage), 2 reflection stages, 20 power stages
// (two per exponent bit) and 2 output stages.
// Reset clears the valid bits and sets the exponent to 300.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module phong_diffuse_specular_shade import pdss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  pdss_in_t            req_i,
  input  logic                cfg_we_i,
  input  logic [EXP_BITS-1:0] cfg_wdata_i,
  output logic                done_o,
  output pdss_out_t           res_o
);

  localparam int unsigned CRV_BITS = COS_BITS + 3;
  localparam int unsigned DPR_BITS = INTEN_BITS + MAG_BITS;

  logic [EXP_BITS-1:0]        exp_q;
  logic                       accept;
  pdss_side_t                 side_in;
  cvec_t                      n_raw, l_raw, d_raw;

  logic                       dir_vld;
  pdss_side_t                 dir_side;
  dvec_t                      n_dir, l_dir, v_dir;
  logic [2:0]                 dir_ok;

  logic                       cos_vld;
  pdss_side_t                 cos_side;
  logic signed [COS_BITS-1:0] c_nl, c_nv, c_lv;

  // reflection stage 1
  logic [MAG_BITS-1:0]        abs_nl, abs_nv;
  logic [2*MAG_BITS-1:0]      p1_q;
  logic                       neg1_q;
  logic signed [COS_BITS-1:0] clv1_q;
  logic [DPR_BITS-1:0]        dprod1_q;
  pdss_side_t                 side1_q;
  logic                       vld1_q;

  // reflection stage 2
  logic [COS_BITS:0]          t2;
  logic signed [CRV_BITS-1:0] tsg2, crv2;
  logic [MAG_BITS-1:0]        x2_d, x2_q;
  pdss_pside_t                ps2_d, ps2_q;
  logic                       vld2_q;

  logic                       pow_vld;
  pdss_pside_t                pow_side;
  logic [MAG_BITS-1:0]        pow_val;

  // output stages
  logic [DPR_BITS-1:0]        sprod3_q;
  pdss_pside_t                ps3_q;
  logic                       vld3_q;
  pdss_out_t                  res_d, res_q;
  logic                       done_q;

  // Take a request on every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Hold the exponent register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= EXP_RESET;
    end else if (cfg_we_i) begin
      exp_q <= cfg_wdata_i;
    end
  end

  // Clamp intensity at one and unpack the vectors
  always_comb begin
    side_in.inten  = (req_i.light_intensity > FULL_INTEN) ? FULL_INTEN : req_i.light_intensity;
    side_in.shadow = req_i.in_shadow;
    n_raw = {req_i.normal_z, req_i.normal_y, req_i.normal_x};
    l_raw = {req_i.light_z, req_i.light_y, req_i.light_x};
    d_raw = {req_i.view_z, req_i.view_y, req_i.view_x};
  end

  pdss_dir u_dir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .side_i  (side_in),
    .n_i     (n_raw),
    .l_i     (l_raw),
    .d_i     (d_raw),
    .valid_o (dir_vld),
    .side_o  (dir_side),
    .n_o     (n_dir),
    .l_o     (l_dir),
    .v_o     (v_dir),
    .ok_o    (dir_ok)
  );

  pdss_cos u_cos_nl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dir_vld),
    .side_i  (dir_side),
    .a_i     (n_dir),
    .b_i     (l_dir),
    .ok_i    (dir_ok[0] && dir_ok[1]),
    .valid_o (cos_vld),
    .side_o  (cos_side),
    .cos_o   (c_nl)
  );

  pdss_cos u_cos_nv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dir_vld),
    .side_i  (dir_side),
    .a_i     (n_dir),
    .b_i     (v_dir),
    .ok_i    (dir_ok[0] && dir_ok[2]),
    .valid_o (),
    .side_o  (),
    .cos_o   (c_nv)
  );

  pdss_cos u_cos_lv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dir_vld),
    .side_i  (dir_side),
    .a_i     (l_dir),
    .b_i     (v_dir),
    .ok_i    (dir_ok[1] && dir_ok[2]),
    .valid_o (),
    .side_o  (),
    .cos_o   (c_lv)
  );

  // Reflection stage 1: product of the normal cosines and the diffuse product
  assign abs_nl = (c_nl < 0) ? MAG_BITS'(-c_nl) : MAG_BITS'(c_nl);
  assign abs_nv = (c_nv < 0) ? MAG_BITS'(-c_nv) : MAG_BITS'(c_nv);

  always_ff @(posedge clk_i) begin
    p1_q     <= abs_nl * abs_nv;
    neg1_q   <= (c_nl < 0) != (c_nv < 0);
    clv1_q   <= c_lv;
    dprod1_q <= (c_nl > 0) ? (cos_side.inten * abs_nl) : '0;
    side1_q  <= cos_side;
  end

  // Reflection stage 2: cos(R,V), limited at one
  always_comb begin
    t2   = p1_q[FRAC_Q-1 +: COS_BITS+1];
    tsg2 = $signed(CRV_BITS'(t2));
    crv2 = (neg1_q ? -tsg2 : tsg2) - CRV_BITS'(clv1_q);
    x2_d = (crv2 > CRV_BITS'(Q30_ONE)) ? MAG_BITS'(Q30_ONE) : crv2[MAG_BITS-1:0];
    ps2_d.inten  = side1_q.inten;
    ps2_d.shadow = side1_q.shadow;
    ps2_d.diff   = dprod1_q[FRAC_Q +: INTEN_BITS];
    ps2_d.en     = crv2 > CRV_BITS'(0);
  end

  always_ff @(posedge clk_i) begin
    x2_q  <= x2_d;
    ps2_q <= ps2_d;
  end

  pdss_pow u_pow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld2_q),
    .side_i  (ps2_q),
    .x_i     (x2_q),
    .exp_i   (exp_q),
    .valid_o (pow_vld),
    .side_o  (pow_side),
    .pow_o   (pow_val)
  );

  // Specular product, dropped when the highlight cosine is not positive
  always_ff @(posedge clk_i) begin
    sprod3_q <= pow_side.en ? (pow_side.inten * pow_val) : '0;
    ps3_q    <= pow_side;
  end

  // Assemble the result, zero in shadow
  always_comb begin
    if (ps3_q.shadow) begin
      res_d = '0;
    end else begin
      res_d.diffuse_part    = ps3_q.diff;
      res_d.specular_part   = sprod3_q[FRAC_Q +: INTEN_BITS];
      res_d.total_intensity = (INTEN_BITS+1)'(ps3_q.diff)
                            + (INTEN_BITS+1)'(sprod3_q[FRAC_Q +: INTEN_BITS]);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld1_q <= cos_vld;
      vld2_q <= vld1_q;
      vld3_q <= pow_vld;
      done_q <= vld3_q;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[hdl/pdss_dir.sv]
// ----------------------------------------------------------------------------
// pdss_dir
// Reduces the normal, light and ray vectors to directions with magnitudes
// below 2^15 in three stages; the ray direction is negated into the view.
// ----------------------------------------------------------------------------
module pdss_dir import pdss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  pdss_side_t side_i,
  input  cvec_t      n_i,
  input  cvec_t      l_i,
  input  cvec_t      d_i,
  output logic       valid_o,
  output pdss_side_t side_o,
  output dvec_t      n_o,
  output dvec_t      l_o,
  output dvec_t      v_o,
  output logic [2:0] ok_o
);

  cvec_t                raw [3];
  logic [COMP_BITS-1:0] mag1_d [3][3];
  logic [COMP_BITS-1:0] mag1_q [3][3];
  logic [2:0]           neg1_d [3];
  logic [2:0]           neg1_q [3];
  logic [COMP_BITS-1:0] max1_d [3];
  logic [COMP_BITS-1:0] max1_q [3];
  logic [COMP_BITS-1:0] mag2_q [3][3];
  logic [2:0]           neg2_q [3];
  logic [BL_BITS-1:0]   bl2_d [3];
  logic [BL_BITS-1:0]   bl2_q [3];
  dvec_t                dir3_d [3];
  dvec_t                dir3_q [3];
  logic [2:0]           ok3_d;
  logic [2:0]           ok3_q;
  logic [2:0]           vld_q;
  pdss_side_t           side_q [3];

  assign raw[0] = n_i;
  assign raw[1] = l_i;
  assign raw[2] = d_i;

  // Stage 1: magnitudes and largest magnitude per vector
  always_comb begin
    for (int g = 0; g < 3; g++) begin
      max1_d[g] = '0;
      for (int k = 0; k < 3; k++) begin
        neg1_d[g][k] = raw[g][k][COMP_BITS-1];
        mag1_d[g][k] = neg1_d[g][k] ? COMP_BITS'(~raw[g][k] + 1'b1) : COMP_BITS'(raw[g][k]);
        if (mag1_d[g][k] > max1_d[g]) begin
          max1_d[g] = mag1_d[g][k];
        end
      end
    end
  end

  // Stage 2: bit length of the largest magnitude
  always_comb begin
    for (int g = 0; g < 3; g++) begin
      bl2_d[g] = '0;
      for (int b = 0; b < COMP_BITS; b++) begin
        if (max1_q[g][b]) begin
          bl2_d[g] = BL_BITS'(b + 1);
        end
      end
    end
  end

  // Stage 3: shift into direction range and restore the sign
  always_comb begin
    logic [COMP_BITS-1:0] sh;
    logic [DIR_BITS-1:0]  q;
    logic                 negf;
    sh   = '0;
    q    = '0;
    negf = 1'b0;
    for (int g = 0; g < 3; g++) begin
      for (int k = 0; k < 3; k++) begin
        if (bl2_q[g] > BL_BITS'(DIR_BITS)) begin
          sh = mag2_q[g][k] >> (bl2_q[g] - BL_BITS'(DIR_BITS));
        end else begin
          sh = mag2_q[g][k] << (BL_BITS'(DIR_BITS) - bl2_q[g]);
        end
        q    = sh[DIR_BITS-1:0];
        // flip the ray into the view vector
        negf = neg2_q[g][k] ^ (g == 2);
        dir3_d[g][k] = negf ? -dir_t'({1'b0, q}) : dir_t'({1'b0, q});
      end
      ok3_d[g] = (bl2_q[g] != '0);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    side_q[1] <= side_q[0];
    side_q[2] <= side_q[1];
    for (int g = 0; g < 3; g++) begin
      max1_q[g] <= max1_d[g];
      neg1_q[g] <= neg1_d[g];
      neg2_q[g] <= neg1_q[g];
      bl2_q[g]  <= bl2_d[g];
      dir3_q[g] <= dir3_d[g];
      for (int k = 0; k < 3; k++) begin
        mag1_q[g][k] <= mag1_d[g][k];
        mag2_q[g][k] <= mag1_q[g][k];
      end
    end
    ok3_q <= ok3_d;
  end

  assign valid_o = vld_q[2];
  assign side_o  = side_q[2];
  assign n_o     = dir3_q[0];
  assign l_o     = dir3_q[1];
  assign v_o     = dir3_q[2];
  assign ok_o    = ok3_q;

endmodule

[hdl/pdss_cos.sv]
// ----------------------------------------------------------------------------
// pdss_cos
// Cosine of two directions as signed Q30: dot and norms, norm product,
// a one-bit-per-stage square root and a one-bit-per-stage divider.
// ----------------------------------------------------------------------------
module pdss_cos import pdss_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  pdss_side_t                 side_i,
  input  dvec_t                      a_i,
  input  dvec_t                      b_i,
  input  logic                       ok_i,
  output logic                       valid_o,
  output pdss_side_t                 side_o,
  output logic signed [COS_BITS-1:0] cos_o
);

  localparam int unsigned NRM_BITS  = 32;
  localparam int unsigned PROD_BITS = 2 * NRM_BITS;
  localparam int unsigned NSQ       = PROD_BITS / 2;
  localparam int unsigned NDV       = MAG_BITS;
  localparam int unsigned REM_BITS  = NRM_BITS + 2;
  localparam int unsigned DOT_BITS  = NRM_BITS + 2;

  typedef struct packed {
    logic [NRM_BITS-1:0] mag;
    logic                neg;
    logic                ok;
    pdss_side_t          side;
  } tag_t;

  // stage 1
  logic signed [NRM_BITS-1:0] pab1_q [3];
  logic [NRM_BITS-1:0]        paa1_q [3];
  logic [NRM_BITS-1:0]        pbb1_q [3];
  logic                       ok1_q;
  pdss_side_t                 side1_q;
  logic                       vld1_q;
  // stage 2
  logic signed [DOT_BITS-1:0] dot2;
  tag_t                       tag2_d, tag2_q;
  logic [NRM_BITS-1:0]        na2_q, nb2_q;
  logic                       vld2_q;
  // square root stages, entry 0 holds the norm product
  logic [PROD_BITS-1:0]       sv_d [NSQ+1];
  logic [PROD_BITS-1:0]       sv_q [NSQ+1];
  logic [PROD_BITS-1:0]       sr_d [NSQ+1];
  logic [PROD_BITS-1:0]       sr_q [NSQ+1];
  tag_t                       sqt_q [NSQ+1];
  logic [NSQ:0]               sqv_q;
  // divider stages
  logic [REM_BITS-1:0]        rm_s [NDV];
  logic [MAG_BITS-1:0]        qt_s [NDV];
  logic [NRM_BITS-1:0]        dn_s [NDV];
  tag_t                       dvt_s [NDV];
  logic [REM_BITS-1:0]        rm_d [NDV];
  logic [REM_BITS-1:0]        rm_q [NDV];
  logic [MAG_BITS-1:0]        qt_d [NDV];
  logic [MAG_BITS-1:0]        qt_q [NDV];
  logic [NRM_BITS-1:0]        dn_q [NDV];
  tag_t                       dvt_q [NDV];
  logic [NDV-1:0]             dvv_q;
  // output
  logic signed [COS_BITS-1:0] cos_d, cos_q;
  pdss_side_t                 side_q;
  logic                       vld_q;

  // Stage 1: component products
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      pab1_q[k] <= a_i[k] * b_i[k];
      paa1_q[k] <= a_i[k] * a_i[k];
      pbb1_q[k] <= b_i[k] * b_i[k];
    end
    ok1_q   <= ok_i;
    side1_q <= side_i;
  end

  // Stage 2: dot product magnitude and squared norms
  always_comb begin
    dot2 = DOT_BITS'(pab1_q[0]) + DOT_BITS'(pab1_q[1]) + DOT_BITS'(pab1_q[2]);
    tag2_d.neg  = dot2 < 0;
    tag2_d.mag  = (dot2 < 0) ? NRM_BITS'(-dot2) : NRM_BITS'(dot2);
    tag2_d.ok   = ok1_q;
    tag2_d.side = side1_q;
  end

  always_ff @(posedge clk_i) begin
    tag2_q <= tag2_d;
    na2_q  <= paa1_q[0] + paa1_q[1] + paa1_q[2];
    nb2_q  <= pbb1_q[0] + pbb1_q[1] + pbb1_q[2];
  end

  // Square root: entry 0 takes the norm product, each later entry one result bit
  always_comb begin
    logic [PROD_BITS-1:0] bitv;
    logic [PROD_BITS-1:0] trial;
    bitv  = '0;
    trial = '0;
    sv_d[0] = na2_q * nb2_q;
    sr_d[0] = '0;
    for (int j = 0; j < NSQ; j++) begin
      bitv  = PROD_BITS'(1) << (PROD_BITS - 2 - 2 * j);
      trial = sr_q[j] + bitv;
      if (sv_q[j] >= trial) begin
        sv_d[j+1] = sv_q[j] - trial;
        sr_d[j+1] = (sr_q[j] >> 1) + bitv;
      end else begin
        sv_d[j+1] = sv_q[j];
        sr_d[j+1] = sr_q[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= NSQ; j++) begin
      sv_q[j] <= sv_d[j];
      sr_q[j] <= sr_d[j];
    end
    sqt_q[0] <= tag2_q;
    for (int j = 1; j <= NSQ; j++) begin
      sqt_q[j] <= sqt_q[j-1];
    end
  end

  // Divider: one quotient bit per stage, integer bit first
  always_comb begin
    logic                ge;
    logic [REM_BITS-1:0] dif;
    ge  = 1'b0;
    dif = '0;
    rm_s[0]  = REM_BITS'(sqt_q[NSQ].mag);
    qt_s[0]  = '0;
    dn_s[0]  = sr_q[NSQ][NRM_BITS-1:0];
    dvt_s[0] = sqt_q[NSQ];
    for (int j = 1; j < NDV; j++) begin
      rm_s[j]  = rm_q[j-1];
      qt_s[j]  = qt_q[j-1];
      dn_s[j]  = dn_q[j-1];
      dvt_s[j] = dvt_q[j-1];
    end
    for (int j = 0; j < NDV; j++) begin
      ge      = rm_s[j] >= REM_BITS'(dn_s[j]);
      dif     = ge ? (rm_s[j] - REM_BITS'(dn_s[j])) : rm_s[j];
      rm_d[j] = {dif[REM_BITS-2:0], 1'b0};
      qt_d[j] = {qt_s[j][MAG_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NDV; j++) begin
      rm_q[j]  <= rm_d[j];
      qt_q[j]  <= qt_d[j];
      dn_q[j]  <= dn_s[j];
      dvt_q[j] <= dvt_s[j];
    end
  end

  // Output: restore the sign, zero when a vector was all zero
  always_comb begin
    logic signed [COS_BITS-1:0] qx;
    qx = $signed(COS_BITS'(qt_q[NDV-1]));
    if (!dvt_q[NDV-1].ok) begin
      cos_d = '0;
    end else if (dvt_q[NDV-1].neg) begin
      cos_d = -qx;
    end else begin
      cos_d = qx;
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q  <= cos_d;
    side_q <= dvt_q[NDV-1].side;
  end

  // Advance valid bits through every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      sqv_q  <= '0;
      dvv_q  <= '0;
      vld_q  <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      sqv_q  <= {sqv_q[NSQ-1:0], vld2_q};
      dvv_q  <= {dvv_q[NDV-2:0], sqv_q[NSQ]};
      vld_q  <= dvv_q[NDV-1];
    end
  end

  assign valid_o = vld_q;
  assign side_o  = side_q;
  assign cos_o   = cos_q;

endmodule

[hdl/pdss_pow.sv]
// ----------------------------------------------------------------------------
// pdss_pow
// Q30 power by square and multiply, most significant exponent bit first:
// one multiplier and one register per stage, two stages per exponent bit.
// ----------------------------------------------------------------------------
module pdss_pow import pdss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  pdss_pside_t         side_i,
  input  logic [MAG_BITS-1:0] x_i,
  input  logic [EXP_BITS-1:0] exp_i,
  output logic                valid_o,
  output pdss_pside_t         side_o,
  output logic [MAG_BITS-1:0] pow_o
);

  localparam int unsigned NST = 2 * EXP_BITS;

  logic [MAG_BITS-1:0]   acc_s [NST];
  logic [MAG_BITS-1:0]   x_s   [NST];
  pdss_pside_t           sd_s  [NST];
  logic [MAG_BITS-1:0]   acc_d [NST];
  logic [MAG_BITS-1:0]   acc_q [NST];
  logic [MAG_BITS-1:0]   x_q   [NST];
  pdss_pside_t           sd_q  [NST];
  logic [NST-1:0]        vld_q;

  // Even stage squares, odd stage multiplies by x when the exponent bit is set
  always_comb begin
    logic [2*MAG_BITS-1:0] prod;
    prod = '0;
    acc_s[0] = MAG_BITS'(Q30_ONE);
    x_s[0]   = x_i;
    sd_s[0]  = side_i;
    for (int s = 1; s < NST; s++) begin
      acc_s[s] = acc_q[s-1];
      x_s[s]   = x_q[s-1];
      sd_s[s]  = sd_q[s-1];
    end
    for (int s = 0; s < NST; s++) begin
      if (s % 2 == 0) begin
        prod     = acc_s[s] * acc_s[s];
        acc_d[s] = prod[FRAC_Q +: MAG_BITS];
      end else if (exp_i[EXP_BITS - 1 - s / 2]) begin
        prod     = acc_s[s] * x_s[s];
        acc_d[s] = prod[FRAC_Q +: MAG_BITS];
      end else begin
        prod     = '0;
        acc_d[s] = acc_s[s];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NST; s++) begin
      acc_q[s] <= acc_d[s];
      x_q[s]   <= x_s[s];
      sd_q[s]  <= sd_s[s];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NST-1];
  assign side_o  = sd_q[NST-1];
  assign pow_o   = acc_q[NST-1];

endmodule
